// File: design/sap_pkg.sv
// Shared types, constants and helpers for the stereo allpass phaser.
// No dependencies; used by sap_ctrl, sap_datapath and stereo_allpass_phaser.
package sap_pkg;

  // Allpass stages per channel and derived widths
  localparam int MAX_STAGES = 12;
  localparam int PAIRS_MAX  = MAX_STAGES / 2;
  localparam int STG_W      = $clog2(MAX_STAGES);

  // Register indexes of the configuration port
  localparam logic [2:0] REG_BYPASS      = 3'd0;
  localparam logic [2:0] REG_FEEDBACK    = 3'd1;
  localparam logic [2:0] REG_WET_MIX     = 3'd2;
  localparam logic [2:0] REG_MOD_SCALE   = 3'd3;
  localparam logic [2:0] REG_MOD_BIAS    = 3'd4;
  localparam logic [2:0] REG_STAGE_PAIRS = 3'd5;

  typedef struct packed {
    logic               bypass;
    logic signed [15:0] feedback;
    logic [16:0]        wet_mix;
    logic signed [15:0] mod_scale;
    logic signed [15:0] mod_bias;
    logic [2:0]         stage_pairs;
  } cfg_t;

  // Datapath operations, each run as a multiply state then an execute state
  typedef enum logic [2:0] {
    OP_COEF = 3'd0,
    OP_DRY  = 3'd1,
    OP_FB   = 3'd2,
    OP_STG  = 3'd3,
    OP_MIXD = 3'd4,
    OP_MIXW = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             ch;
    logic [STG_W-1:0] idx;
    logic             mul;
    logic             exec;
    logic             load_in;
    logic             load_out;
  } cmd_t;

  // Clamp to the signed 24-bit sample range
  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// File: design/sap_ctrl.sv
// Sequencer for the phaser: walks coefficient, per-channel and stage operations.
// Depends on sap_pkg; drives sap_datapath through a cmd_t.
module sap_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  sap_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sap_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                    state, state_next;
  sap_pkg::op_t              op, op_next;
  logic                      ch, ch_next;
  logic [sap_pkg::STG_W-1:0] idx, idx_next;
  logic                      out_valid_next;
  logic [7:0]                pairs_w;
  logic [7:0]                two_p;
  logic [sap_pkg::STG_W-1:0] idx_top;
  logic                      accept, load_out;

  // Active stage count, limited to the built chain
  always_comb begin
    pairs_w = 8'(cfg.stage_pairs);
    if (pairs_w > 8'(sap_pkg::PAIRS_MAX)) begin
      pairs_w = 8'(sap_pkg::PAIRS_MAX);
    end
    two_p   = pairs_w << 1;
    idx_top = sap_pkg::STG_W'(two_p - 8'd1);
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // Next state and operation
  always_comb begin
    state_next = state;
    op_next    = op;
    ch_next    = ch;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_next    = sap_pkg::OP_COEF;
          ch_next    = 1'b0;
          state_next = cfg.bypass ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_MUL;
        unique case (op)
          sap_pkg::OP_COEF: op_next = sap_pkg::OP_DRY;
          sap_pkg::OP_DRY:  op_next = sap_pkg::OP_FB;
          sap_pkg::OP_FB: begin
            if (pairs_w == 8'd0) begin
              op_next = sap_pkg::OP_MIXD;
            end else begin
              op_next  = sap_pkg::OP_STG;
              idx_next = idx_top;
            end
          end
          sap_pkg::OP_STG: begin
            if (idx == '0) begin
              op_next = sap_pkg::OP_MIXD;
            end else begin
              idx_next = idx - sap_pkg::STG_W'(1);
            end
          end
          sap_pkg::OP_MIXD: op_next = sap_pkg::OP_MIXW;
          sap_pkg::OP_MIXW: begin
            if (ch) begin
              state_next = S_DONE;
            end else begin
              ch_next = 1'b1;
              op_next = sap_pkg::OP_DRY;
            end
          end
          default: op_next = sap_pkg::OP_COEF;
        endcase
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= sap_pkg::OP_COEF;
      ch        <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      ch        <= ch_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Command bundle
  always_comb begin
    cmd.op       = op;
    cmd.ch       = ch;
    cmd.idx      = idx;
    cmd.mul      = (state == S_MUL);
    cmd.exec     = (state == S_EXEC);
    cmd.load_in  = accept;
    cmd.load_out = load_out;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted while a word is in flight");

  a_stage_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op == sap_pkg::OP_STG) |-> (32'(idx) < sap_pkg::MAX_STAGES))
    else $error("stage index beyond chain");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !(state == S_IDLE && $past(state) == S_DONE))
    else $error("result loaded over a waiting word");

endmodule

// File: design/sap_datapath.sv
// Shared multiplier, coefficient divide, allpass history and output registers.
// Depends on sap_pkg; sequenced by sap_ctrl.
module sap_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sap_pkg::cfg_t      cfg,
  input  sap_pkg::cmd_t      cmd,
  input  logic signed [23:0] left_in,
  input  logic signed [23:0] right_in,
  input  logic signed [15:0] mod_value,
  output logic signed [23:0] left_out,
  output logic signed [23:0] right_out
);

  logic signed [23:0] x_hist [2][sap_pkg::MAX_STAGES];
  logic signed [23:0] y_hist [2][sap_pkg::MAX_STAGES];
  logic signed [23:0] last_wet [2];
  logic signed [23:0] xin [2];
  logic signed [23:0] dry [2];
  logic signed [23:0] res [2];
  logic [16:0]        u;
  logic signed [15:0] coef;
  logic signed [23:0] acc;
  logic signed [44:0] prod;
  logic signed [44:0] macc;

  logic signed [25:0] op_a;
  logic signed [18:0] op_b;
  logic [16:0]        fb_mag;
  logic signed [18:0] att;
  logic [17:0]        mix_sat;
  logic signed [23:0] x_rd, y_rd;

  logic               neg;
  logic [44:0]        mag;
  logic [31:0]        t;
  logic [15:0]        q0;
  logic [17:0]        r;
  logic [16:0]        q;
  logic signed [18:0] csum;
  logic signed [15:0] coef_new;
  logic signed [44:0] rnd15;
  logic signed [44:0] rnd17;
  logic signed [45:0] mix_sum;
  logic signed [23:0] fb_in, stg_y, mix_y;

  // Derived gains
  always_comb begin
    fb_mag  = cfg.feedback[15] ? 17'(-18'(cfg.feedback)) : 17'(cfg.feedback);
    att     = 19'sd131072 - $signed(19'(fb_mag));
    mix_sat = (cfg.wet_mix > 17'd65536) ? 18'd65536 : 18'(cfg.wet_mix);
    x_rd    = x_hist[cmd.ch][cmd.idx];
    y_rd    = y_hist[cmd.ch][cmd.idx];
  end

  // Multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.op)
      sap_pkg::OP_COEF: begin
        op_a = $signed(26'(u));
        op_b = 19'(cfg.mod_scale);
      end
      sap_pkg::OP_DRY: begin
        op_a = 26'(xin[cmd.ch]);
        op_b = att;
      end
      sap_pkg::OP_FB: begin
        op_a = 26'(last_wet[cmd.ch]);
        op_b = 19'(cfg.feedback);
      end
      sap_pkg::OP_STG: begin
        op_a = 26'(y_rd) + 26'(acc);
        op_b = 19'(coef);
      end
      sap_pkg::OP_MIXD: begin
        op_a = 26'(dry[cmd.ch]);
        op_b = 19'sd65536 - $signed(19'(mix_sat));
      end
      sap_pkg::OP_MIXW: begin
        op_a = 26'(acc);
        op_b = $signed(19'(mix_sat));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Coefficient: rounded divide by 65535, bias, clamp
  always_comb begin
    neg  = prod[44];
    mag  = neg ? 45'(-prod) : 45'(prod);
    t    = 32'(mag) + 32'd32767;
    q0   = t[31:16];
    r    = 18'(t[15:0]) + 18'(q0);
    q    = 17'(q0) + 17'(r >= 18'd65535) + 17'(r >= 18'd131070);
    csum = (neg ? -$signed(19'(q)) : $signed(19'(q))) + 19'(cfg.mod_bias);
    if (csum > 19'sd32767) begin
      coef_new = 16'sh7FFF;
    end else if (csum < -19'sd32768) begin
      coef_new = 16'sh8000;
    end else begin
      coef_new = csum[15:0];
    end
  end

  // Rounded shifts and stage results
  always_comb begin
    rnd15   = (prod + 45'sd16384) >>> 15;
    rnd17   = (prod + 45'sd65536) >>> 17;
    mix_sum = (46'(macc) + 46'(prod) + 46'sd32768) >>> 16;
    fb_in   = sap_pkg::sat24(48'(dry[cmd.ch]) + 48'(rnd15));
    stg_y   = sap_pkg::sat24(48'(rnd15) - 48'(x_rd));
    mix_y   = sap_pkg::sat24(48'(mix_sum));
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      xin[0] <= left_in;
      xin[1] <= right_in;
      res[0] <= left_in;
      res[1] <= right_in;
      u      <= 17'(mod_value) + 17'd32768;
    end
    if (cmd.mul) begin
      prod <= 45'(op_a) * 45'(op_b);
    end
    if (cmd.exec) begin
      case (cmd.op)
        sap_pkg::OP_COEF: coef <= coef_new;
        sap_pkg::OP_DRY:  dry[cmd.ch] <= rnd17[23:0];
        sap_pkg::OP_FB:   acc <= fb_in;
        sap_pkg::OP_STG:  acc <= stg_y;
        sap_pkg::OP_MIXD: macc <= prod;
        sap_pkg::OP_MIXW: res[cmd.ch] <= mix_y;
        default:          acc <= acc;
      endcase
    end
    if (cmd.load_out) begin
      left_out  <= res[0];
      right_out <= res[1];
    end
  end

  // Allpass history and feedback memory, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        last_wet[c] <= '0;
        for (int s = 0; s < sap_pkg::MAX_STAGES; s++) begin
          x_hist[c][s] <= '0;
          y_hist[c][s] <= '0;
        end
      end
    end else if (cmd.exec) begin
      if (cmd.op == sap_pkg::OP_STG) begin
        y_hist[cmd.ch][cmd.idx] <= stg_y;
        x_hist[cmd.ch][cmd.idx] <= acc;
      end
      if (cmd.op == sap_pkg::OP_MIXW) begin
        last_wet[cmd.ch] <= acc;
      end
    end
  end

endmodule

// File: design/stereo_allpass_phaser.sv
// Stereo allpass-chain phaser: config registers, sequencer and datapath.
// Each word runs through one shared multiplier as a sequence of operations that grows with
// the active stage pairs; bypass skips them. A new word is accepted only once the previous
// one has reached the output register. A full output register holds the sequencer.
// Reset (rst, synchronous) clears all history, feedback state and loads defaults.
// Depends on sap_pkg, sap_ctrl and sap_datapath.
module stereo_allpass_phaser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // left_in[23:0], right_in[47:24], mod_value[63:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // left_out[23:0], right_out[47:24]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  sap_pkg::cfg_t      cfg;
  sap_pkg::cmd_t      cmd;
  logic signed [23:0] left_out, right_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bypass      <= 1'b0;
      cfg.feedback    <= '0;
      cfg.wet_mix     <= 17'd32768;
      cfg.mod_scale   <= 16'sd32767;
      cfg.mod_bias    <= '0;
      cfg.stage_pairs <= 3'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sap_pkg::REG_BYPASS:      cfg.bypass      <= cfg_data[0];
        sap_pkg::REG_FEEDBACK:    cfg.feedback    <= cfg_data[15:0];
        sap_pkg::REG_WET_MIX:     cfg.wet_mix     <= cfg_data;
        sap_pkg::REG_MOD_SCALE:   cfg.mod_scale   <= cfg_data[15:0];
        sap_pkg::REG_MOD_BIAS:    cfg.mod_bias    <= cfg_data[15:0];
        sap_pkg::REG_STAGE_PAIRS: cfg.stage_pairs <= cfg_data[2:0];
        default:                  cfg.bypass      <= cfg.bypass;
      endcase
    end
  end

  sap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  sap_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .left_in   (s_tdata[23:0]),
    .right_in  (s_tdata[47:24]),
    .mod_value (s_tdata[63:48]),
    .left_out  (left_out),
    .right_out (right_out)
  );

  assign m_tdata = {right_out, left_out};

endmodule
